@@ sv/swdd_pkg.sv @@
// ----------------------------------------------------------------------------
// swdd_pkg
// Shared types, constants and functions of the sliding-window distinct
// detector.
// ----------------------------------------------------------------------------
package swdd_pkg;

    localparam int WINDOW_MAX    = 16;
    localparam int ALPHABET_SIZE = 26;

    localparam int SYM_W   = 5;
    localparam int CFG_W   = 5;
    localparam int CNT_W   = 5;
    localparam int POS_W   = 32;
    localparam int SLOT_W  = $clog2(WINDOW_MAX);
    localparam int SIZE_W  = $clog2(WINDOW_MAX + 1);

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [SIZE_W-1:0] t_size;

    typedef struct packed {
        logic sym_ok;
        logic rem_en;
        t_sym sym;
        t_sym old;
        t_pos taken;
    } t_front;

    function automatic t_size eff_size(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return t_size'(1);
        end
        if (int'(v) > WINDOW_MAX) begin
            return t_size'(WINDOW_MAX);
        end
        return t_size'(v);
    endfunction

endpackage

@@ sv/swdd_count_bank.sv @@
// ----------------------------------------------------------------------------
// swdd_count_bank
// Per-letter event counter memory with two registered read ports, one write
// port, per-entry valid bits and forwarding of the last write.
// ----------------------------------------------------------------------------
module swdd_count_bank
    import swdd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    input  logic i_re,
    input  t_sym i_raddr0,
    input  t_sym i_raddr1,
    input  logic i_we,
    input  t_sym i_waddr,
    input  t_cnt i_wdata,
    output t_cnt o_rdata0,
    output t_cnt o_rdata1
);

    t_cnt                     r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_valid;
    t_sym                     r_raddr0;
    t_sym                     r_raddr1;
    t_cnt                     r_rd0;
    t_cnt                     r_rd1;
    logic                     r_w_en;
    t_sym                     r_w_addr;
    t_cnt                     r_w_data;

    always_comb begin
        o_rdata0 = (r_w_en && (r_w_addr == r_raddr0)) ? r_w_data : r_rd0;
        o_rdata1 = (r_w_en && (r_w_addr == r_raddr1)) ? r_w_data : r_rd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_w_en  <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_w_en <= i_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_addr <= i_waddr;
        r_w_data <= i_wdata;
        if (i_re) begin
            r_raddr0 <= i_raddr0;
            r_raddr1 <= i_raddr1;
            if ((int'(i_raddr0) < ALPHABET_SIZE) && r_valid[i_raddr0]) begin
                r_rd0 <= r_mem[i_raddr0];
            end else begin
                r_rd0 <= '0;
            end
            if ((int'(i_raddr1) < ALPHABET_SIZE) && r_valid[i_raddr1]) begin
                r_rd1 <= r_mem[i_raddr1];
            end else begin
                r_rd1 <= '0;
            end
        end else begin
            r_rd0 <= o_rdata0;
            r_rd1 <= o_rdata1;
        end
    end

endmodule

@@ sv/swdd_window.sv @@
// ----------------------------------------------------------------------------
// swdd_window
// Ring of recent symbols, write slot and saturating symbol counter. Gives
// the leaving symbol and the window state for each incoming symbol.
// ----------------------------------------------------------------------------
module swdd_window
    import swdd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_clear,
    input  t_size  i_size,
    input  logic   i_take,
    input  t_sym   i_symbol,
    output t_front o_front
);

    t_sym  r_ring [WINDOW_MAX];
    t_slot r_slot;
    t_pos  r_taken;

    t_slot slot;
    t_size slot_inc;
    t_slot n_slot;
    t_pos  n_taken;
    logic  sym_ok;

    always_comb begin
        slot     = (t_size'(r_slot) >= i_size) ? '0 : r_slot;
        slot_inc = t_size'(slot) + t_size'(1);
        n_slot   = (slot_inc >= i_size) ? '0 : t_slot'(slot_inc);
        n_taken  = (r_taken == POS_MAX) ? r_taken : r_taken + t_pos'(1);
        sym_ok   = int'(i_symbol) < ALPHABET_SIZE;

        o_front.sym_ok = sym_ok;
        o_front.rem_en = r_taken >= t_pos'(i_size);
        o_front.sym    = i_symbol;
        o_front.old    = r_ring[slot];
        o_front.taken  = sym_ok ? n_taken : r_taken;
    end

    always_ff @(posedge i_clk) begin
        if (i_take && sym_ok) begin
            r_ring[slot] <= i_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_slot  <= '0;
            r_taken <= '0;
        end else if (i_take && sym_ok) begin
            r_slot  <= n_slot;
            r_taken <= n_taken;
        end
    end

endmodule

@@ sv/sliding_window_distinct_detector.sv @@
// ----------------------------------------------------------------------------
// sliding_window_distinct_detector
// A result passes through the stage-one and output registers after its
// symbol is accepted. Throughput: one symbol per cycle while the output is
// not stalled, set by the single read-modify-write pass over the two
// letter-count memories, with forwarding of the last write. Reset and every
// write of the window size clear the stream; the window size resets to four.
// ----------------------------------------------------------------------------
module sliding_window_distinct_detector
    import swdd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_sym             i_symbol,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_window_distinct,
    output logic             o_marker_seen,
    output t_pos             o_first_marker_pos
);

    logic [CFG_W-1:0] r_cfg_size;
    t_size            size;
    logic             cfg_write;

    t_front front;
    t_front r_s1;
    logic   r_s1_valid;
    t_cnt   r_repeat;
    logic   r_found;
    t_pos   r_pos;

    logic   r_o_valid;
    logic   r_o_distinct;
    logic   r_o_seen;
    t_pos   r_o_pos;

    logic   out_free;
    logic   s1_adv;
    logic   accept;

    t_cnt   add_sym;
    t_cnt   add_old;
    t_cnt   rem_sym;
    t_cnt   rem_old;
    t_cnt   cnt_old;
    t_cnt   cnt_old_dec;
    t_cnt   cnt_sym;
    logic   dec;
    logic   inc;
    t_cnt   rep1;
    t_cnt   n_repeat;
    logic   distinct;
    logic   n_found;
    t_pos   n_pos;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign size        = eff_size(r_cfg_size);

    assign out_free   = !r_o_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    swdd_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_write),
        .i_size   (size),
        .i_take   (accept),
        .i_symbol (i_symbol),
        .o_front  (front)
    );

    swdd_count_bank u_add_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_write),
        .i_re     (accept && front.sym_ok),
        .i_raddr0 (front.sym),
        .i_raddr1 (front.old),
        .i_we     (s1_adv && r_s1.sym_ok && inc),
        .i_waddr  (r_s1.sym),
        .i_wdata  (add_sym + t_cnt'(1)),
        .o_rdata0 (add_sym),
        .o_rdata1 (add_old)
    );

    swdd_count_bank u_rem_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_write),
        .i_re     (accept && front.sym_ok),
        .i_raddr0 (front.sym),
        .i_raddr1 (front.old),
        .i_we     (s1_adv && r_s1.sym_ok && dec),
        .i_waddr  (r_s1.old),
        .i_wdata  (rem_old + t_cnt'(1)),
        .o_rdata0 (rem_sym),
        .o_rdata1 (rem_old)
    );

    // A letter's window count is the difference of its arrivals and departures.
    always_comb begin
        cnt_old     = add_old - rem_old;
        cnt_old_dec = cnt_old - t_cnt'(1);
        dec         = r_s1.rem_en && (cnt_old != '0);
        rep1        = (dec && (cnt_old_dec == t_cnt'(1)) && (r_repeat != '0))
                      ? r_repeat - t_cnt'(1) : r_repeat;
        cnt_sym     = (dec && (r_s1.old == r_s1.sym)) ? cnt_old_dec
                                                      : add_sym - rem_sym;
        inc         = cnt_sym != CNT_MAX;
        n_repeat    = (inc && (cnt_sym == t_cnt'(1)) && (rep1 != CNT_MAX))
                      ? rep1 + t_cnt'(1) : rep1;
        distinct    = r_s1.sym_ok && (r_s1.taken >= t_pos'(size))
                      && (n_repeat == '0);
        n_found     = r_found || distinct;
        n_pos       = (distinct && !r_found) ? r_s1.taken : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= SIZE_RESET;
        end else if (cfg_write) begin
            r_cfg_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= front;
        end
        if (s1_adv) begin
            r_o_distinct <= distinct;
            r_o_seen     <= n_found;
            r_o_pos      <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_write) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_repeat   <= '0;
            r_found    <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
                r_found   <= n_found;
                r_pos     <= n_pos;
                if (r_s1.sym_ok) begin
                    r_repeat <= n_repeat;
                end
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_window_distinct  = r_o_distinct;
    assign o_marker_seen      = r_o_seen;
    assign o_first_marker_pos = r_o_pos;

endmodule

@@ tb/sliding_window_distinct_detector_tb.sv @@
// ----------------------------------------------------------------------------
// sliding_window_distinct_detector_tb
// Self-checking bench for the sliding-window distinct detector. A driver
// feeds letter symbols and window-size writes from a planned queue with
// random gaps. A monitor applies random output stalls, predicts every result
// from its own copy of the window state, and compares each result field by
// field. Window-size writes are made only once all results have drained.
// ----------------------------------------------------------------------------
module sliding_window_distinct_detector_tb;
    import swdd_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 110;

    typedef enum logic [1:0] {
        STEP_SYMBOL,
        STEP_SIZE,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind       kind;
        logic [CFG_W-1:0] value;
    } t_step;

    typedef struct packed {
        logic window_distinct;
        logic marker_seen;
        t_pos first_marker_pos;
    } t_verdict;

    logic             i_clk              = 1'b0;
    logic             i_rst_n            = 1'b0;
    logic             i_cfg_valid        = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data         = '0;
    logic             i_in_valid         = 1'b0;
    logic             o_in_stall;
    t_sym             i_symbol           = '0;
    logic             o_out_valid;
    logic             i_out_stall        = 1'b0;
    logic             o_window_distinct;
    logic             o_marker_seen;
    t_pos             o_first_marker_pos;

    t_step            symbol_plan [$];
    t_verdict         expected_verdicts [$];
    logic             verdicts_idle = 1'b1;

    logic [CFG_W-1:0] window_size_reg;
    t_sym             ring [WINDOW_MAX];
    int               ring_slot;
    t_cnt             letter_tally [ALPHABET_SIZE];
    t_cnt             repeated_letters;
    t_pos             taken_count;
    t_pos             latched_pos;
    logic             latched;

    int fail_count      = 0;
    int symbols_fed     = 0;
    int ignored_symbols = 0;
    int size_writes     = 0;
    int results_checked = 0;
    int distinct_hits   = 0;

    sliding_window_distinct_detector dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_symbol           (i_symbol),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_distinct  (o_window_distinct),
        .o_marker_seen      (o_marker_seen),
        .o_first_marker_pos (o_first_marker_pos)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int window_span(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(v);
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic restart_stream(input logic [CFG_W-1:0] size_value);
        for (int i = 0; i < WINDOW_MAX; i++) begin
            ring[i] = '0;
        end
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            letter_tally[i] = '0;
        end
        ring_slot        = 0;
        repeated_letters = '0;
        taken_count      = '0;
        latched_pos      = '0;
        latched          = 1'b0;
        window_size_reg  = size_value;
    endtask

    task automatic predict_verdict(input t_sym sym, output t_verdict v);
        int   span;
        int   slot;
        t_sym old;
        span              = window_span(window_size_reg);
        v.window_distinct = 1'b0;
        if (int'(sym) < ALPHABET_SIZE) begin
            slot = (ring_slot >= span) ? 0 : ring_slot;
            if (taken_count >= t_pos'(span)) begin
                old = ring[slot];
                if (int'(old) < ALPHABET_SIZE && letter_tally[old] != '0) begin
                    letter_tally[old] = letter_tally[old] - 1'b1;
                    if (letter_tally[old] == t_cnt'(1) && repeated_letters != '0) begin
                        repeated_letters = repeated_letters - 1'b1;
                    end
                end
            end
            ring[slot] = sym;
            if (letter_tally[sym] != CNT_MAX) begin
                letter_tally[sym] = letter_tally[sym] + 1'b1;
                if (letter_tally[sym] == t_cnt'(2) && repeated_letters != CNT_MAX) begin
                    repeated_letters = repeated_letters + 1'b1;
                end
            end
            slot      = slot + 1;
            ring_slot = (slot >= span) ? 0 : slot;
            if (taken_count != POS_MAX) begin
                taken_count = taken_count + 1'b1;
            end
            if (taken_count >= t_pos'(span) && repeated_letters == '0) begin
                v.window_distinct = 1'b1;
                if (!latched) begin
                    latched     = 1'b1;
                    latched_pos = taken_count;
                end
            end
        end
        v.marker_seen      = latched;
        v.first_marker_pos = latched_pos;
    endtask

    task automatic queue_symbol(input t_sym s);
        t_step step;
        step.kind  = STEP_SYMBOL;
        step.value = s;
        symbol_plan.push_back(step);
    endtask

    task automatic queue_size(input logic [CFG_W-1:0] v);
        t_step step;
        step.kind  = STEP_SIZE;
        step.value = v;
        symbol_plan.push_back(step);
    endtask

    task automatic queue_drain();
        t_step step;
        step.kind  = STEP_DRAIN;
        step.value = '0;
        symbol_plan.push_back(step);
    endtask

    always @(posedge i_clk) begin : driver
        logic  next_in_valid;
        logic  next_cfg_valid;
        t_step step;
        int    send_gap;
        int    calm_in;
        int    settle_left;
        next_in_valid  = i_in_valid;
        next_cfg_valid = i_cfg_valid;
        if (!i_rst_n) begin
            next_in_valid  = 1'b0;
            next_cfg_valid = 1'b0;
            send_gap       = 0;
            calm_in        = 0;
            settle_left    = SETTLE_CYCLES;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                next_in_valid = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                next_cfg_valid = 1'b0;
            end
            if (!next_in_valid && !next_cfg_valid && symbol_plan.size() != 0) begin
                case (symbol_plan[0].kind)
                    STEP_SYMBOL: begin
                        if (send_gap != 0) begin
                            send_gap = send_gap - 1;
                        end else begin
                            step          = symbol_plan.pop_front();
                            i_symbol      <= t_sym'(step.value);
                            next_in_valid = 1'b1;
                            if (calm_in != 0) begin
                                calm_in = calm_in - 1;
                            end else begin
                                send_gap = draw_gap();
                                if ($urandom_range(0, 19) == 0) begin
                                    calm_in = $urandom_range(20, 80);
                                end
                            end
                        end
                    end
                    default: begin
                        if (verdicts_idle && !i_in_valid && !i_cfg_valid) begin
                            if (settle_left != 0) begin
                                settle_left = settle_left - 1;
                            end else begin
                                step = symbol_plan.pop_front();
                                if (step.kind == STEP_SIZE) begin
                                    i_cfg_data     <= step.value;
                                    next_cfg_valid = 1'b1;
                                end
                                settle_left = SETTLE_CYCLES;
                            end
                        end else begin
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                endcase
            end
        end
        i_in_valid  <= next_in_valid;
        i_cfg_valid <= next_cfg_valid;
    end

    always @(posedge i_clk) begin : monitor
        t_verdict want;
        logic     next_stall;
        int       hold_left;
        int       calm_out;
        if (!i_rst_n) begin
            restart_stream(SIZE_RESET);
            hold_left = 0;
            calm_out  = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (expected_verdicts.size() == 0) begin
                    $error("Result transaction arrived with no expectation pending.");
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (want.window_distinct != o_window_distinct) begin
                        $error("window_distinct: expected %0d, got %0d",
                               want.window_distinct, o_window_distinct);
                        fail_count++;
                    end
                    if (want.marker_seen != o_marker_seen) begin
                        $error("marker_seen: expected %0d, got %0d",
                               want.marker_seen, o_marker_seen);
                        fail_count++;
                    end
                    if (want.first_marker_pos != o_first_marker_pos) begin
                        $error("first_marker_pos: expected %0d, got %0d",
                               want.first_marker_pos, o_first_marker_pos);
                        fail_count++;
                    end
                    if (want.window_distinct) begin
                        distinct_hits++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                restart_stream(i_cfg_data);
                size_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                predict_verdict(i_symbol, want);
                expected_verdicts.push_back(want);
                symbols_fed++;
                if (int'(i_symbol) >= ALPHABET_SIZE) begin
                    ignored_symbols++;
                end
            end
        end
        if (hold_left == 0) begin
            if (calm_out != 0) begin
                calm_out = calm_out - 1;
            end else begin
                hold_left = draw_gap();
                if ($urandom_range(0, 19) == 0) begin
                    calm_out = $urandom_range(20, 80);
                end
            end
        end
        if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            next_stall = 1'b1;
        end else begin
            next_stall = 1'b0;
        end
        i_out_stall   <= next_stall;
        verdicts_idle <= (expected_verdicts.size() == 0);
    end

    initial begin : stimulus
        int               span;
        int               r;
        int               drain_at;
        logic             clash;
        t_sym             letter;
        t_sym             recent [$];
        logic [CFG_W-1:0] size_val;

        // Reset window of four: a distinct run, a repeat, ignored letters and a slide.
        queue_symbol(t_sym'(0));
        queue_symbol(t_sym'(1));
        queue_symbol(t_sym'(2));
        queue_symbol(t_sym'(3));
        queue_symbol(t_sym'(3));
        queue_symbol(t_sym'(31));
        queue_symbol(t_sym'(26));
        queue_symbol(t_sym'(25));
        queue_symbol(t_sym'(24));
        queue_symbol(t_sym'(23));
        queue_drain();
        // A size of zero behaves as one, so every letter is a distinct window.
        queue_size('0);
        queue_symbol(t_sym'(5));
        queue_symbol(t_sym'(5));
        queue_symbol(t_sym'(6));
        queue_size(CFG_W'(1));
        queue_symbol(t_sym'(7));
        queue_symbol(t_sym'(31));
        // An oversized value is clamped to the largest window.
        queue_size('1);
        queue_symbol(t_sym'(0));
        queue_symbol(t_sym'(0));
        queue_symbol(t_sym'(0));
        queue_symbol(t_sym'(0));
        queue_symbol(t_sym'(25));

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: size_val = CFG_W'(16);
                1: size_val = CFG_W'(2);
                2: size_val = CFG_W'(17);
                3: size_val = CFG_W'(1);
                default: size_val = CFG_W'($urandom_range(0, 31));
            endcase
            queue_size(size_val);
            span     = window_span(size_val);
            drain_at = $urandom_range(10, PHASE_ITEMS - 10);
            recent.delete();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == drain_at) begin
                    queue_drain();
                end
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    letter = t_sym'($urandom_range(ALPHABET_SIZE, 31));
                end else begin
                    if (r < 25) begin
                        letter = t_sym'($urandom_range(0, ALPHABET_SIZE - 1));
                    end else begin
                        // Mostly pick a letter absent from the current window.
                        do begin
                            letter = t_sym'($urandom_range(0, ALPHABET_SIZE - 1));
                            clash  = 1'b0;
                            foreach (recent[j]) begin
                                if (recent[j] == letter) begin
                                    clash = 1'b1;
                                end
                            end
                        end while (clash);
                    end
                    recent.push_back(letter);
                    if (recent.size() > span - 1) begin
                        recent.delete(0);
                    end
                end
                queue_symbol(letter);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (symbol_plan.size() != 0 || i_in_valid || i_cfg_valid ||
               expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);

        if (expected_verdicts.size() != 0) begin
            $error("%0d expected results never arrived.", expected_verdicts.size());
            fail_count++;
        end
        $display("Fed %0d symbols (%0d outside the alphabet) over %0d window-size writes.",
                 symbols_fed, ignored_symbols, size_writes);
        $display("Checked %0d results, %0d of them distinct windows.",
                 results_checked, distinct_hits);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1200000;
        $display("Some tests failed");
        $finish;
    end

endmodule
